>>> src/kmeans_clustering_defines.svh
// Assertion macros shared by the k-means cluster RTL.
// Needs clk_i and rst_ni in the module that expands them.
`ifndef KMEANS_CLUSTERING_DEFINES_SVH
`define KMEANS_CLUSTERING_DEFINES_SVH

// same-cycle implication
`define KMC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/kmc_pkg.sv
// Shared constants, codes and bus types of the k-means cluster block.
// No dependencies.
package kmc_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int MAX_K       = 8;
  localparam int MAX_DIM     = 8;
  localparam int ITER_LIMIT  = 800;
  localparam int MOVE_LIMIT  = 4295;

  localparam int VAL_W       = 32;
  localparam int DIFF_W      = VAL_W + 1;
  localparam int K_W         = 4;
  localparam int ITER_W      = 10;
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int FIELD_IDX_W = 3;
  localparam int CIDX_W      = $clog2(MAX_K);
  localparam int DIDX_W      = $clog2(MAX_DIM);
  localparam int DIM_CW      = $clog2(MAX_DIM + 1);
  localparam int PT_AW       = $clog2(MAX_POINTS);
  localparam int PT_W        = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W      = PT_AW + DIDX_W;
  localparam int SUM_W       = PT_AW + VAL_W;
  localparam int CNT_W       = PT_W;
  localparam int ACC_W       = 2 * VAL_W + DIDX_W;
  localparam int STEP_W      = $clog2(SUM_W);

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_K    = 2'd1,
    ST_BAD_ITER = 2'd2,
    ST_BAD_DATA = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SEED,
    OP_CLEAR,
    OP_DIST,
    OP_ADD,
    OP_UPDATE,
    OP_READ
  } op_kind_e;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CHECK,
    S_ERR,
    S_SEED,
    S_PASS,
    S_DIST,
    S_DIST_WAIT,
    S_TOK,
    S_ADD,
    S_UPD,
    S_UPD_WAIT,
    S_PASS_END,
    S_EMIT_RD,
    S_EMIT_PUT
  } state_e;

  // broadcast to every cell
  typedef struct packed {
    op_kind_e           kind;
    logic [CIDX_W-1:0]  target;
    logic [DIDX_W-1:0]  d;
    logic               first;
    logic [VAL_W-1:0]   value;
  } op_t;

  // nearest-centroid token passed along the row
  typedef struct packed {
    logic               valid;
    logic               have;
    logic [ACC_W-1:0]   sqd;
    logic [CIDX_W-1:0]  idx;
  } tok_t;

  typedef struct packed {
    logic busy;
    logic moved;
  } cell_stat_t;

endpackage

>>> src/kmeans_clustering.sv
// Lloyd k-means cluster block: top level with point memory, sequencer,
// cell row and result register. Uses kmc_pkg, kmc_cell and the macro header.
//
// Use: write num_clusters (index 0) and max_iterations (index 1) while idle.
// Stream points one coordinate per word on the input channel; end_of_point
// closes a point, end_of_set closes the last point and starts the run.
// Loading accepts one word per cycle (one write port of the point memory).
// After end_of_set the row of cells runs Lloyd passes; a pass is paced by
// the single read port of the point memory, the token row of MAX_K cells
// and the bit-serial divider in each cell. Results then leave one word at
// a time, through a read state and a put state, centroid-major, last set
// on the final word; an error gives one word.
// The input stalls from end_of_set until the final result is registered.
// A stalled output word holds; the block waits for it.
// Reset clears the load state and sets num_clusters to 2 and
// max_iterations to 400; the point memory needs no clearing.
`include "kmeans_clustering_defines.svh"
module kmeans_clustering (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kmc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [kmc_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [kmc_pkg::VAL_W-1:0] coord_value_i,
  input  logic                            end_of_point_i,
  input  logic                            end_of_set_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [kmc_pkg::FIELD_IDX_W-1:0] cluster_index_o,
  output logic [kmc_pkg::FIELD_IDX_W-1:0] coord_index_o,
  output logic signed [kmc_pkg::VAL_W-1:0] centroid_value_o,
  output logic [1:0]                      status_o,
  output logic                            last_o
);
  import kmc_pkg::*;

  state_e            state_q, state_d;
  logic [K_W-1:0]    nc_q;
  logic [ITER_W-1:0] mi_q;

  logic [PT_W-1:0]   pt_q;
  logic [DIM_CW-1:0] dim_q, cp_q, cp_inc;
  logic              lerr_q, wr_ok, in_acc;

  logic [VAL_W-1:0]  pmem [2**ADDR_W];
  logic [VAL_W-1:0]  rdata_q;
  logic [ADDR_W-1:0] rd_addr;
  logic [VAL_W-1:0]  first_pt_q [MAX_DIM];

  logic [CIDX_W-1:0] c_q, win_q;
  logic [DIDX_W-1:0] d_q;
  logic [PT_AW-1:0]  p_q;
  logic [ITER_W-1:0] it_q;
  status_e           status_q, status_d;

  op_t               op_d, op_q, op_cell;
  logic              from_mem_d, from_mem_q;
  logic              tok_start, out_load, out_free, clear_load;
  logic              c_last, d_last, p_last, all_idle, any_busy, any_moved, stop;

  tok_t              tok_chain [MAX_K+1];
  logic [VAL_W-1:0]  cent_sel  [MAX_K];
  cell_stat_t        stat      [MAX_K];

  logic                   out_valid_q, out_last_q;
  logic [FIELD_IDX_W-1:0] out_ci_q, out_di_q;
  logic [VAL_W-1:0]       out_val_q;
  status_e                out_st_q;

  assign in_stall_o = state_q != S_LOAD;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wr_ok      = (cp_q < DIM_CW'(MAX_DIM)) && (pt_q < PT_W'(MAX_POINTS));
  assign cp_inc     = wr_ok ? cp_q + DIM_CW'(1) : cp_q;

  assign c_last = (K_W'(c_q) + K_W'(1)) == nc_q;
  assign d_last = (DIM_CW'(d_q) + DIM_CW'(1)) == dim_q;
  assign p_last = (PT_W'(p_q) + PT_W'(1)) == pt_q;
  assign stop   = !any_moved || ((it_q + ITER_W'(1)) >= mi_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    any_busy  = 1'b0;
    any_moved = 1'b0;
    for (int i = 0; i < MAX_K; i++) begin
      any_busy  = any_busy  || stat[i].busy;
      any_moved = any_moved || stat[i].moved;
    end
    all_idle = (op_q.kind == OP_NONE) && !any_busy;
  end

  always_comb begin
    status_d = ST_OK;
    if ((nc_q < K_W'(2)) || (nc_q > K_W'(MAX_K))) begin
      status_d = ST_BAD_K;
    end else if ((mi_q < ITER_W'(2)) || (mi_q >= ITER_W'(ITER_LIMIT))) begin
      status_d = ST_BAD_ITER;
    end else if (lerr_q || (pt_q == '0) || (dim_q == '0)) begin
      status_d = ST_BAD_DATA;
    end else if (PT_W'(nc_q) >= pt_q) begin
      status_d = ST_BAD_K;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:      if (in_acc && end_of_set_i) state_d = S_CHECK;
      S_CHECK:     state_d = (status_d == ST_OK) ? S_SEED : S_ERR;
      S_ERR:       if (out_free) state_d = S_LOAD;
      S_SEED:      if (d_last && c_last) state_d = S_PASS;
      S_PASS:      state_d = S_DIST;
      S_DIST:      if (d_last) state_d = S_DIST_WAIT;
      S_DIST_WAIT: if (all_idle) state_d = S_TOK;
      S_TOK:       if (tok_chain[MAX_K].valid) state_d = S_ADD;
      S_ADD:       if (d_last) state_d = p_last ? S_UPD : S_DIST;
      S_UPD:       state_d = S_UPD_WAIT;
      S_UPD_WAIT:  if (all_idle) state_d = d_last ? S_PASS_END : S_UPD;
      S_PASS_END:  state_d = stop ? S_EMIT_RD : S_PASS;
      S_EMIT_RD:   state_d = S_EMIT_PUT;
      S_EMIT_PUT:  if (out_free) state_d = (c_last && d_last) ? S_LOAD : S_EMIT_RD;
      default:     state_d = S_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    op_d       = '0;
    op_d.kind  = OP_NONE;
    from_mem_d = 1'b0;
    rd_addr    = {p_q, d_q};
    tok_start  = 1'b0;
    out_load   = 1'b0;
    clear_load = 1'b0;
    case (state_q)
      S_ERR: begin
        out_load   = out_free;
        clear_load = out_free;
      end
      S_SEED: begin
        op_d.kind   = OP_SEED;
        op_d.target = c_q;
        op_d.d      = d_q;
        from_mem_d  = 1'b1;
        rd_addr     = {PT_AW'(c_q), d_q};
      end
      S_PASS: begin
        op_d.kind = OP_CLEAR;
      end
      S_DIST: begin
        op_d.kind  = OP_DIST;
        op_d.d     = d_q;
        op_d.first = d_q == '0;
        from_mem_d = 1'b1;
      end
      S_DIST_WAIT: begin
        tok_start = all_idle;
      end
      S_ADD: begin
        op_d.kind   = OP_ADD;
        op_d.target = win_q;
        op_d.d      = d_q;
        op_d.first  = d_q == '0;
        from_mem_d  = 1'b1;
      end
      S_UPD: begin
        op_d.kind  = OP_UPDATE;
        op_d.d     = d_q;
        op_d.first = d_q == '0;
        op_d.value = first_pt_q[d_q];
      end
      S_EMIT_RD: begin
        op_d.kind = OP_READ;
        op_d.d    = d_q;
      end
      S_EMIT_PUT: begin
        op_d.kind  = OP_READ;
        op_d.d     = d_q;
        out_load   = out_free;
        clear_load = out_free && c_last && d_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      nc_q       <= K_W'(2);
      mi_q       <= ITER_W'(400);
      pt_q       <= '0;
      dim_q      <= '0;
      cp_q       <= '0;
      lerr_q     <= 1'b0;
      op_q       <= '0;
      from_mem_q <= 1'b0;
      c_q        <= '0;
      d_q        <= '0;
      p_q        <= '0;
      it_q       <= '0;
      win_q      <= '0;
      status_q   <= ST_OK;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      from_mem_q <= from_mem_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_NUM_CLUSTERS: nc_q <= cfg_data_i[K_W-1:0];
          REG_MAX_ITER:     mi_q <= cfg_data_i[ITER_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        if (!wr_ok) lerr_q <= 1'b1;
        if (end_of_point_i || end_of_set_i) begin
          if (pt_q == '0) begin
            dim_q <= cp_inc;
          end else if (cp_inc != dim_q) begin
            lerr_q <= 1'b1;
          end
          if (pt_q < PT_W'(MAX_POINTS)) pt_q <= pt_q + PT_W'(1);
          cp_q <= '0;
        end else begin
          cp_q <= cp_inc;
        end
      end
      if (clear_load) begin
        pt_q   <= '0;
        dim_q  <= '0;
        cp_q   <= '0;
        lerr_q <= 1'b0;
      end
      case (state_q)
        S_CHECK: begin
          status_q <= status_d;
          c_q      <= '0;
          d_q      <= '0;
          it_q     <= '0;
        end
        S_SEED: begin
          d_q <= d_last ? '0 : d_q + DIDX_W'(1);
          if (d_last) c_q <= c_q + CIDX_W'(1);
        end
        S_PASS: begin
          p_q <= '0;
          d_q <= '0;
        end
        S_DIST: begin
          d_q <= d_last ? '0 : d_q + DIDX_W'(1);
        end
        S_TOK: begin
          if (tok_chain[MAX_K].valid) win_q <= tok_chain[MAX_K].idx;
        end
        S_ADD: begin
          d_q <= d_last ? '0 : d_q + DIDX_W'(1);
          if (d_last) p_q <= p_q + PT_AW'(1);
        end
        S_UPD_WAIT: begin
          if (all_idle) d_q <= d_last ? '0 : d_q + DIDX_W'(1);
        end
        S_PASS_END: begin
          it_q <= it_q + ITER_W'(1);
          c_q  <= '0;
          d_q  <= '0;
        end
        S_EMIT_PUT: begin
          if (out_free) begin
            d_q <= d_last ? '0 : d_q + DIDX_W'(1);
            if (d_last) c_q <= c_q + CIDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // point memory: load-side write port, sequencer read port
  always_ff @(posedge clk_i) begin
    if (in_acc && wr_ok) begin
      pmem[{pt_q[PT_AW-1:0], cp_q[DIDX_W-1:0]}] <= coord_value_i;
      if (pt_q == '0) first_pt_q[cp_q[DIDX_W-1:0]] <= coord_value_i;
    end
    rdata_q <= pmem[rd_addr];
  end

  always_comb begin
    op_cell       = op_q;
    op_cell.value = from_mem_q ? rdata_q : op_q.value;
  end

  always_comb begin
    tok_chain[0]       = '0;
    tok_chain[0].valid = tok_start;
  end

  for (genvar g = 0; g < MAX_K; g++) begin : g_cell
    kmc_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cell_idx_i     (CIDX_W'(g)),
      .num_clusters_i (nc_q),
      .op_i           (op_cell),
      .tok_i          (tok_chain[g]),
      .tok_o          (tok_chain[g+1]),
      .cent_o         (cent_sel[g]),
      .stat_o         (stat[g])
    );
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (state_q == S_ERR) begin
        out_ci_q   <= '0;
        out_di_q   <= '0;
        out_val_q  <= '0;
        out_st_q   <= status_q;
        out_last_q <= 1'b1;
      end else begin
        out_ci_q   <= FIELD_IDX_W'(c_q);
        out_di_q   <= FIELD_IDX_W'(d_q);
        out_val_q  <= cent_sel[c_q];
        out_st_q   <= ST_OK;
        out_last_q <= c_last && d_last;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cluster_index_o  = out_ci_q;
  assign coord_index_o    = out_di_q;
  assign centroid_value_o = out_val_q;
  assign status_o         = out_st_q;
  assign last_o           = out_last_q;

  `KMC_ASSERT_IMPL(a_error_is_last, out_valid_q && (out_st_q != ST_OK), out_last_q, "error word without last")
  `KMC_ASSERT_IMPL(a_token_in_tok_state, tok_chain[MAX_K].valid, state_q == S_TOK, "stray nearest-centroid token")
  `KMC_ASSERT_IMPL(a_emit_in_range, out_load && (state_q == S_EMIT_PUT), K_W'(c_q) < nc_q, "result beyond cluster count")

endmodule

>>> src/kmc_div.sv
// Bit-serial restoring divider: unsigned sum magnitude by member count.
// One quotient bit per cycle. Depends on kmc_pkg.
module kmc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [kmc_pkg::SUM_W-1:0] dividend_i,
  input  logic [kmc_pkg::CNT_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [kmc_pkg::SUM_W-1:0] quo_o
);
  import kmc_pkg::*;

  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q, den_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [CNT_W:0]    trial, trial_sub;
  logic              ge;

  assign trial     = {rem_q, quo_q[SUM_W-1]};
  assign ge        = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == STEP_W'(SUM_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_W-2:0], ge};
      rem_q <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> src/kmc_cell.sv
// One centroid cell: coordinates, sums, count, squared-distance pipeline,
// divider and a stage of the nearest-centroid token row. Uses kmc_pkg, kmc_div.
`include "kmeans_clustering_defines.svh"
module kmc_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [kmc_pkg::CIDX_W-1:0] cell_idx_i,
  input  logic [kmc_pkg::K_W-1:0]    num_clusters_i,
  input  kmc_pkg::op_t               op_i,
  input  kmc_pkg::tok_t              tok_i,
  output kmc_pkg::tok_t              tok_o,
  output logic [kmc_pkg::VAL_W-1:0]  cent_o,
  output kmc_pkg::cell_stat_t        stat_o
);
  import kmc_pkg::*;

  logic [VAL_W-1:0]  cent_q [MAX_DIM];
  logic [SUM_W-1:0]  sum_q  [MAX_DIM];
  logic [CNT_W-1:0]  cnt_q;
  logic [ACC_W-1:0]  acc_q;

  logic              s1_v_q, s1_first_q;
  logic [DIFF_W-1:0] diff_q;
  logic              s2_v_q, s2_first_q;
  logic [33:0]       phh_q;
  logic [32:0]       phl_q;
  logic [31:0]       pll_q;

  logic [VAL_W-1:0]  old_q, v_q;
  logic [DIDX_W-1:0] upd_d_q;
  logic              upd_first_q, neg_q, fire_q;
  tok_t              tok_q;

  logic              active, sel, dist_in, upd_in, div_start;
  logic              s1_load, s1_first;
  logic [VAL_W-1:0]  op_a, op_b;
  logic [DIFF_W-1:0] diff_d;
  logic [DIFF_W-1:0] mag;
  logic [16:0]       mh;
  logic [15:0]       ml;
  logic [33:0]       phh_d;
  logic [32:0]       phl_d;
  logic [31:0]       pll_d;
  logic [ACC_W-1:0]  sq;
  logic [SUM_W-1:0]  sum_sel, sum_mag;
  logic              div_busy, div_done, take;
  logic [SUM_W-1:0]  quo;
  logic [VAL_W-1:0]  quo_lo;

  assign active   = K_W'(cell_idx_i) < num_clusters_i;
  assign sel      = op_i.target == cell_idx_i;
  assign dist_in  = (op_i.kind == OP_DIST) && active;
  assign upd_in   = (op_i.kind == OP_UPDATE) && active;
  assign sum_sel  = sum_q[op_i.d];
  assign sum_mag  = sum_sel[SUM_W-1] ? (~sum_sel + SUM_W'(1)) : sum_sel;
  assign div_start = upd_in && (cnt_q != '0);
  assign cent_o   = cent_q[op_i.d];

  // stage 1 operands: a point coordinate, or the new centroid value
  always_comb begin
    s1_load  = dist_in || fire_q;
    op_a     = dist_in ? cent_q[op_i.d] : old_q;
    op_b     = dist_in ? op_i.value : v_q;
    s1_first = dist_in ? op_i.first : upd_first_q;
    diff_d   = {op_a[VAL_W-1], op_a} - {op_b[VAL_W-1], op_b};
  end

  assign mag   = diff_q[DIFF_W-1] ? (~diff_q + DIFF_W'(1)) : diff_q;
  assign mh    = mag[32:16];
  assign ml    = mag[15:0];
  assign phh_d = mh * mh;
  assign phl_d = mh * ml;
  assign pll_d = ml * ml;
  assign sq    = ACC_W'({phh_q, 32'b0}) + ACC_W'({phl_q, 17'b0}) + ACC_W'(pll_q);

  assign quo_lo = quo[VAL_W-1:0];
  assign take   = active && (!tok_i.have || (acc_q < tok_i.sqd));

  kmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .divisor_i  (cnt_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      fire_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      s1_v_q <= s1_load;
      s2_v_q <= s1_v_q;
      fire_q <= (upd_in && (cnt_q == '0)) || div_done;
      tok_q.valid <= tok_i.valid;
      if (tok_i.valid) begin
        tok_q.have <= tok_i.have || take;
        tok_q.sqd  <= take ? acc_q : tok_i.sqd;
        tok_q.idx  <= take ? cell_idx_i : tok_i.idx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i.kind)
      OP_SEED: begin
        if (sel) cent_q[op_i.d] <= op_i.value;
      end
      OP_CLEAR: begin
        for (int i = 0; i < MAX_DIM; i++) sum_q[i] <= '0;
        cnt_q <= '0;
      end
      OP_ADD: begin
        if (sel) begin
          sum_q[op_i.d] <= sum_sel + {{(SUM_W-VAL_W){op_i.value[VAL_W-1]}}, op_i.value};
          if (op_i.first) cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      OP_UPDATE: begin
        if (active) begin
          old_q       <= cent_q[op_i.d];
          upd_d_q     <= op_i.d;
          upd_first_q <= op_i.first;
          neg_q       <= sum_sel[SUM_W-1];
          if (cnt_q == '0) v_q <= op_i.value;
        end
      end
      default: begin
      end
    endcase
    if (div_done) v_q <= neg_q ? (~quo_lo + VAL_W'(1)) : quo_lo;
    // commit the new coordinate as its move enters the pipeline
    if (fire_q) cent_q[upd_d_q] <= v_q;
    if (s1_load) begin
      diff_q     <= diff_d;
      s1_first_q <= s1_first;
    end
    if (s1_v_q) begin
      phh_q      <= phh_d;
      phl_q      <= phl_d;
      pll_q      <= pll_d;
      s2_first_q <= s1_first_q;
    end
    if (s2_v_q) acc_q <= s2_first_q ? sq : acc_q + sq;
  end

  assign tok_o        = tok_q;
  // the quotient still has to reach the move pipeline while done is high
  assign stat_o.busy  = div_busy || div_done || fire_q || s1_v_q || s2_v_q;
  assign stat_o.moved = active && (acc_q >= ACC_W'(MOVE_LIMIT));

  `KMC_ASSERT_IMPL(a_div_count_nonzero, div_busy, cnt_q != '0, "divider runs on empty cluster")
  `KMC_ASSERT_NEXT(a_fire_feeds_pipe, fire_q, s1_v_q, "centroid move not squared")
  `KMC_ASSERT_NEXT(a_token_advances, tok_i.valid, tok_q.valid, "token lost in cell")

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the k-means cluster block: streams point sets,
// predicts the centroid words in-bench and checks every result word.
// Depends on kmc_pkg and the kmeans_clustering RTL.
`timescale 1ns / 1ps
module tb_top;
  import kmc_pkg::*;

  localparam int CYCLE_LIMIT = 40000000;
  localparam int SETTLE = 12;

  typedef struct {
    logic [2:0]  cl;
    logic [2:0]  co;
    logic [31:0] val;
    status_e     st;
    logic        lst;
  } centroid_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_NUM_CLUSTERS;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [VAL_W-1:0] coord_value = '0;
  logic end_of_point = 1'b0;
  logic end_of_set = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FIELD_IDX_W-1:0] cluster_index, coord_index;
  logic signed [VAL_W-1:0] centroid_value;
  logic [1:0] status;
  logic last;

  always #1 clk = ~clk;

  kmeans_clustering dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .coord_value_i(coord_value), .end_of_point_i(end_of_point),
    .end_of_set_i(end_of_set),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .cluster_index_o(cluster_index), .coord_index_o(coord_index),
    .centroid_value_o(centroid_value), .status_o(status), .last_o(last)
  );

  // in-bench copy of the block's state
  int unsigned k_cfg = 2;
  int unsigned iter_cfg = 400;
  logic signed [31:0] pts [MAX_POINTS*MAX_DIM];
  int unsigned n_pts, dim_pts, pos_pts;
  logic load_bad;
  centroid_word_t centroid_q[$];

  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int stall_mode = 1;
  int sent = 0;

  function automatic logic [71:0] sq_dist(input logic signed [31:0] a[MAX_DIM],
                                          input logic signed [31:0] b[MAX_DIM],
                                          input int unsigned dim);
    logic [71:0] acc;
    logic [71:0] m;
    longint df;
    acc = '0;
    for (int i = 0; i < dim; i++) begin
      df = longint'(a[i]) - longint'(b[i]);
      m = (df < 0) ? -df : df;
      acc += m * m;
    end
    return acc;
  endfunction

  function automatic void run_lloyd(input int unsigned k, input int unsigned n,
                                    input int unsigned dim);
    logic signed [31:0] cen [MAX_K][MAX_DIM];
    logic signed [31:0] nxt [MAX_K][MAX_DIM];
    logic signed [31:0] pv [MAX_DIM];
    longint sums [MAX_K][MAX_DIM];
    int members [MAX_K];
    logic [71:0] best_d, dd;
    int best;
    bit moved;
    for (int c = 0; c < k; c++)
      for (int d = 0; d < MAX_DIM; d++) cen[c][d] = pts[c*MAX_DIM+d];
    for (int it = 0; it < iter_cfg; it++) begin
      moved = 0;
      for (int c = 0; c < MAX_K; c++) begin
        members[c] = 0;
        for (int d = 0; d < MAX_DIM; d++) sums[c][d] = 0;
      end
      for (int p = 0; p < n; p++) begin
        for (int d = 0; d < MAX_DIM; d++) pv[d] = pts[p*MAX_DIM+d];
        best = 0;
        best_d = sq_dist(cen[0], pv, dim);
        for (int c = 1; c < k; c++) begin
          dd = sq_dist(cen[c], pv, dim);
          if (dd < best_d) begin
            best_d = dd;
            best = c;
          end
        end
        for (int d = 0; d < dim; d++) sums[best][d] += longint'(pv[d]);
        members[best]++;
      end
      for (int c = 0; c < k; c++)
        for (int d = 0; d < MAX_DIM; d++)
          nxt[c][d] = (d >= dim) ? cen[c][d] :
                      (members[c] != 0) ? 32'(sums[c][d] / longint'(members[c])) : pts[d];
      for (int c = 0; c < k; c++)
        if (sq_dist(cen[c], nxt[c], dim) >= MOVE_LIMIT) moved = 1;
      cen = nxt;
      if (!moved) break;
    end
    for (int c = 0; c < k; c++)
      for (int d = 0; d < dim; d++)
        centroid_q.push_back('{3'(c), 3'(d), cen[c][d], ST_OK,
                               (c == k-1) && (d == dim-1)});
  endfunction

  function automatic void clear_load();
    n_pts = 0;
    dim_pts = 0;
    pos_pts = 0;
    load_bad = 0;
  endfunction

  // take one accepted word into the model
  function automatic void absorb_word(input logic signed [31:0] v, input logic eop,
                                      input logic eos);
    status_e st;
    if (pos_pts >= MAX_DIM || n_pts >= MAX_POINTS) load_bad = 1;
    else begin
      pts[n_pts*MAX_DIM+pos_pts] = v;
      pos_pts++;
    end
    if (eop || eos) begin
      if (n_pts == 0) dim_pts = pos_pts;
      else if (pos_pts != dim_pts) load_bad = 1;
      if (n_pts < MAX_POINTS) n_pts++;
      pos_pts = 0;
    end
    if (!eos) return;
    st = ST_OK;
    if (k_cfg < 2 || k_cfg > MAX_K) st = ST_BAD_K;
    else if (iter_cfg < 2 || iter_cfg >= ITER_LIMIT) st = ST_BAD_ITER;
    else if (load_bad || n_pts == 0 || dim_pts == 0) st = ST_BAD_DATA;
    else if (k_cfg >= n_pts) st = ST_BAD_K;
    if (st != ST_OK) centroid_q.push_back('{3'd0, 3'd0, 32'd0, st, 1'b1});
    else run_lloyd(k_cfg, n_pts, dim_pts);
    clear_load();
  endfunction

  task automatic send_word(input logic signed [31:0] v, input logic eop, input logic eos);
    if (gap_left > 0) begin
      in_valid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    in_valid <= 1'b1;
    coord_value <= v;
    end_of_point <= eop;
    end_of_set <= eos;
    do @(posedge clk); while (in_stall);
    absorb_word(v, eop, eos);
    sent++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
  endtask

  // wait for the block to drain, then write one register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    in_valid <= 1'b0;
    wait (centroid_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NUM_CLUSTERS) k_cfg = data & 4'hF;
    else iter_cfg = data;
  endtask

  function automatic logic signed [31:0] rand_coord(input int spread, input int centre);
    if ($urandom_range(0, 19) == 0) return $urandom;
    return centre + $signed($urandom_range(0, 2*spread)) - spread;
  endfunction

  // kind: 0 well formed, 1 length mismatch, 2 overlong point
  task automatic send_set(input int n, input int dim, input int kind);
    int centres [MAX_K];
    int len, bad_p;
    logic eos_eop;
    for (int c = 0; c < MAX_K; c++) centres[c] = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    bad_p = $urandom_range(0, n-1);
    for (int p = 0; p < n; p++) begin
      len = dim;
      if (p == bad_p && kind == 1) len = (dim > 1 && $urandom_range(0, 1)) ? dim-1 : dim+1;
      if (p == bad_p && kind == 2) len = MAX_DIM + $urandom_range(1, 2);
      eos_eop = $urandom_range(0, 1);
      for (int d = 0; d < len; d++)
        send_word(rand_coord(1 << 14, centres[$urandom_range(0, MAX_K-1)]),
                  (d == len-1) && (p != n-1 || eos_eop), (p == n-1) && (d == len-1));
    end
    in_valid <= 1'b0;
  endtask

  // first ten mismatches reported, the rest counted
  task automatic report(input string what, input longint exp_v, input longint act_v);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %0h got %0h at cycle %0d", what, exp_v, act_v, cycles);
  endtask

  always @(posedge clk) begin
    centroid_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (centroid_q.size() == 0) report("unexpected word", 0, centroid_value);
      else begin
        w = centroid_q.pop_front();
        if (cluster_index !== w.cl) report("cluster_index", w.cl, cluster_index);
        if (coord_index !== w.co) report("coord_index", w.co, coord_index);
        if (centroid_value !== w.val) report("centroid_value", w.val, centroid_value);
        if (status !== w.st) report("status", w.st, status);
        if (last !== w.lst) report("last", w.lst, last);
      end
    end
  end

  // receiver stall pattern; a hold-off overrides it
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= (cycles % 7 < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_defaults();
    stall_mode = 0;
    send_word(32'sh7FFFFFFF, 0, 0); send_word(32'sh80000000, 1, 0);
    send_word(32'sh80000000, 0, 0); send_word(32'sh7FFFFFFF, 1, 0);
    send_word(32'sh00000000, 0, 0); send_word(32'shFFFFFFFF, 1, 0);
    send_word(32'sh00010000, 0, 0); send_word(32'shFFFF0000, 1, 1);
    in_valid <= 1'b0;
  endtask

  task automatic test_errors();
    stall_mode = 1;
    write_reg(REG_NUM_CLUSTERS, 0);  send_set(4, 1, 0);
    write_reg(REG_NUM_CLUSTERS, 1);  send_set(4, 1, 0);
    write_reg(REG_NUM_CLUSTERS, 15); send_set(4, 1, 0);
    write_reg(REG_NUM_CLUSTERS, 9);  send_set(4, 1, 0);
    write_reg(REG_NUM_CLUSTERS, 10'h3F2);
    write_reg(REG_MAX_ITER, 0);      send_set(4, 1, 0);
    write_reg(REG_MAX_ITER, 1);      send_set(3, 1, 0);
    write_reg(REG_MAX_ITER, 800);    send_set(3, 1, 0);
    write_reg(REG_MAX_ITER, 1023);   send_set(3, 1, 0);
    write_reg(REG_MAX_ITER, 2);      send_set(3, 2, 1);
    send_set(3, 2, 2);
    send_set(2, 1, 0);
    write_reg(REG_NUM_CLUSTERS, 8);  send_set(8, 1, 0);
    send_set(9, 3, 0);
    write_reg(REG_MAX_ITER, 799);    send_set(10, 8, 0);
    write_reg(REG_NUM_CLUSTERS, 2);  send_set(3, 1, 0);
  endtask

  task automatic test_pressure();
    stall_mode = 0;
    write_reg(REG_MAX_ITER, 20);
    write_reg(REG_NUM_CLUSTERS, 3);
    wait (centroid_q.size() == 0);
    hold_left = 8000;
    send_set(6, 4, 0);
    send_set(5, 2, 0);
    send_set(5, 2, 1);
  endtask

  task automatic test_random();
    int k, dim, roll;
    while (sent < 420) begin
      stall_mode = $urandom_range(0, 2);
      k = $urandom_range(2, MAX_K);
      roll = $urandom_range(0, 19);
      if (roll == 0) k = $urandom_range(0, 15);
      write_reg(REG_NUM_CLUSTERS, CFG_W'(k));
      write_reg(REG_MAX_ITER, (roll == 1) ? CFG_W'($urandom_range(0, 1023)) :
                                            CFG_W'($urandom_range(2, 40)));
      dim = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_DIM) : $urandom_range(1, 3);
      roll = $urandom_range(0, 9);
      send_set($urandom_range(k+1, k+8), dim, (roll == 0) ? 1 : (roll == 1) ? 2 : 0);
    end
  endtask

  initial begin
    clear_load();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_errors();
    test_pressure();
    test_random();
    in_valid <= 1'b0;
    wait (centroid_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
